[rtl/core/hwpg_pkg.sv]
package hwpg_pkg;

    // Defaults for the top-level parameters.
    localparam int HWPG_MAX_RADIUS = 512;
    localparam int HWPG_HUE_BITS   = 16;

    // Register file.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GND_R  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GND_G  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GND_B  = 2'd3;
    localparam logic [CFG_W-1:0]     RADIUS_RESET = 10'd64;
    localparam int RAD_W   = 10;
    localparam int RAD_MIN = 8;

    // Offsets from the disc centre in half pixels: 12-bit signed covers every input.
    localparam int EX_W = 12;

    // Distance path: sum of squares, pipelined square root, rounding, divider.
    localparam int SQ_W        = 23;
    localparam int SQ_SHIFT    = 14;
    localparam int SQRT_STAGES = 19;
    localparam int SQX_W       = 2 * SQRT_STAGES;
    localparam int Q_W         = SQRT_STAGES;
    localparam int REM_W       = Q_W + 3;
    localparam int D_W         = 20;
    localparam int SAT_W       = 17;
    localparam int DIV_STAGES  = SAT_W;
    localparam int N_W         = D_W + 9;
    localparam int DREM_W      = N_W - DIV_STAGES;
    localparam logic [SAT_W-1:0] SAT_ONE = 17'd65536;
    localparam int DIST_LAT    = 1 + SQRT_STAGES + 1 + DIV_STAGES;

    // Hue path: vectoring CORDIC on a 32-bit turn accumulator.
    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_W      = 30;
    localparam int CORDIC_SCALE  = 16;
    localparam int CORDIC_LAT    = 1 + CORDIC_STAGES + 1;
    localparam int HUE_DLY       = DIST_LAT - CORDIC_LAT;

    localparam logic [31:0] CORDIC_ANGLE [CORDIC_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Hue sectors of the six-sector conversion.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

endpackage

[rtl/core/hwpg_dist.sv]
// Distance and saturation: squares, a bit-per-stage square root with rounding,
// then a bit-per-stage restoring divider for the saturation.
module hwpg_dist import hwpg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [EX_W-1:0]  i_ex,
    input  logic signed [EX_W-1:0]  i_ey,
    input  logic [RAD_W-1:0]        i_radius,
    output logic [D_W-1:0]          o_dist,
    output logic [SAT_W-1:0]        o_sat
);

    logic signed [2*EX_W-1:0] w_xx;
    logic signed [2*EX_W-1:0] w_yy;
    logic [SQ_W-1:0]          r_sq;

    assign w_xx = i_ex * i_ex;
    assign w_yy = i_ey * i_ey;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= SQ_W'(w_xx) + SQ_W'(w_yy);
        end
    end

    logic [SQX_W-1:0] r_sx  [SQRT_STAGES-1];
    logic [REM_W-1:0] r_rem [SQRT_STAGES];
    logic [Q_W-1:0]   r_q   [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        logic [SQX_W-1:0] w_x;
        logic [REM_W-1:0] w_rem;
        logic [Q_W-1:0]   w_q;
        logic [REM_W-1:0] w_cur;
        logic [REM_W-1:0] w_trial;

        if (j == 0) begin : g_first
            assign w_x   = SQX_W'({r_sq, SQ_SHIFT'(0)});
            assign w_rem = '0;
            assign w_q   = '0;
        end else begin : g_next
            assign w_x   = r_sx[j-1];
            assign w_rem = r_rem[j-1];
            assign w_q   = r_q[j-1];
        end

        assign w_cur   = {w_rem[REM_W-3:0], w_x[SQX_W-1 -: 2]};
        assign w_trial = REM_W'({w_q, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_trial) begin
                    r_rem[j] <= w_cur - w_trial;
                    r_q[j]   <= {w_q[Q_W-2:0], 1'b1};
                end else begin
                    r_rem[j] <= w_cur;
                    r_q[j]   <= {w_q[Q_W-2:0], 1'b0};
                end
            end
        end

        if (j < SQRT_STAGES - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sx[j] <= {w_x[SQX_W-3:0], 2'b00};
                end
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the floor root.
    logic            w_up;
    logic [D_W-1:0]  r_dist;

    assign w_up = r_rem[SQRT_STAGES-1] > REM_W'(r_q[SQRT_STAGES-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= D_W'(r_q[SQRT_STAGES-1]) + D_W'(w_up);
        end
    end

    // Saturation = (dist * 512 + R) / (2R).
    logic [N_W-1:0]    n_num;
    logic [DREM_W-1:0] w_dv;

    assign n_num = N_W'({r_dist, 9'd0}) + N_W'(i_radius);
    assign w_dv  = DREM_W'({i_radius, 1'b0});

    logic [N_W-1:0]    r_dn   [DIV_STAGES-1];
    logic [DREM_W-1:0] r_drem [DIV_STAGES-1];
    logic [SAT_W-1:0]  r_dq   [DIV_STAGES];
    logic [D_W-1:0]    r_dd   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        localparam int K = DIV_STAGES - 1 - j;
        logic [N_W-1:0]    w_n;
        logic [DREM_W-1:0] w_rem;
        logic [SAT_W-1:0]  w_q;
        logic [D_W-1:0]    w_d;
        logic [DREM_W-1:0] w_cur;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_n   = n_num;
            assign w_rem = n_num[N_W-1 -: DREM_W];
            assign w_q   = '0;
            assign w_d   = r_dist;
        end else begin : g_next
            assign w_n   = r_dn[j-1];
            assign w_rem = r_drem[j-1];
            assign w_q   = r_dq[j-1];
            assign w_d   = r_dd[j-1];
        end

        assign w_cur = {w_rem[DREM_W-2:0], w_n[K]};
        assign w_ge  = w_cur >= w_dv;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[j] <= {w_q[SAT_W-2:0], w_ge};
                r_dd[j] <= w_d;
            end
        end

        if (j < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dn[j]   <= w_n;
                    r_drem[j] <= w_ge ? (w_cur - w_dv) : w_cur;
                end
            end
        end
    end

    assign o_dist = r_dd[DIV_STAGES-1];
    assign o_sat  = (r_dq[DIV_STAGES-1] > SAT_ONE) ? SAT_ONE : r_dq[DIV_STAGES-1];

endmodule

[rtl/core/hwpg_cordic.sv]
// Vectoring CORDIC, one micro-rotation per stage, giving the angle in turns.
module hwpg_cordic import hwpg_pkg::*; #(
    parameter int HUE_BITS = HWPG_HUE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [EX_W-1:0]  i_ex,
    input  logic signed [EX_W-1:0]  i_ey,
    output logic [HUE_BITS-1:0]     o_hue
);

    logic signed [CORDIC_W-1:0] w_x0;
    logic signed [CORDIC_W-1:0] w_y0;
    logic signed [CORDIC_W-1:0] r_px;
    logic signed [CORDIC_W-1:0] r_py;
    logic [31:0]                r_pz;

    assign w_x0 = CORDIC_W'(i_ex) <<< CORDIC_SCALE;
    assign w_y0 = CORDIC_W'(i_ey) <<< CORDIC_SCALE;

    // A vector in the left half plane is turned by half a turn first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ex[EX_W-1]) begin
                r_px <= -w_x0;
                r_py <= -w_y0;
                r_pz <= 32'h8000_0000;
            end else begin
                r_px <= w_x0;
                r_py <= w_y0;
                r_pz <= '0;
            end
        end
    end

    logic signed [CORDIC_W-1:0] r_cx [CORDIC_STAGES-1];
    logic signed [CORDIC_W-1:0] r_cy [CORDIC_STAGES-1];
    logic [31:0]                r_cz [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        logic signed [CORDIC_W-1:0] w_x;
        logic signed [CORDIC_W-1:0] w_y;
        logic [31:0]                w_z;
        logic signed [CORDIC_W-1:0] w_xs;
        logic signed [CORDIC_W-1:0] w_ys;
        logic                       w_neg;

        if (i == 0) begin : g_first
            assign w_x = r_px;
            assign w_y = r_py;
            assign w_z = r_pz;
        end else begin : g_next
            assign w_x = r_cx[i-1];
            assign w_y = r_cy[i-1];
            assign w_z = r_cz[i-1];
        end

        assign w_xs  = w_x >>> i;
        assign w_ys  = w_y >>> i;
        assign w_neg = w_y[CORDIC_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cz[i] <= w_neg ? (w_z - CORDIC_ANGLE[i]) : (w_z + CORDIC_ANGLE[i]);
            end
        end

        if (i < CORDIC_STAGES - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_cx[i] <= w_neg ? (w_x - w_ys) : (w_x + w_ys);
                    r_cy[i] <= w_neg ? (w_y + w_xs) : (w_y - w_xs);
                end
            end
        end
    end

    logic [31:0] w_zr;

    assign w_zr = r_cz[CORDIC_STAGES-1] + (32'd1 << (31 - HUE_BITS));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hue <= w_zr[31 -: HUE_BITS];
        end
    end

endmodule

[rtl/core/hue_wheel_pixel_generator_top.sv]
// Hue wheel pixel generator. Each input transfer carries one pixel coordinate of a square
// whose side is twice the configured disc radius; the matching output transfer carries the
// RGB color of that pixel: hue from the angle around the disc center, saturation from the
// distance to it, full value, blended over the ground color with a one-pixel anti-aliased
// rim, and the plain ground color outside the disc. The block is a fixed pipeline: it takes
// one pixel per clock while the output is not stalled and returns the pixels in order. The
// longest chain is the bit-per-stage square root for the distance followed by the
// bit-per-stage divider for the saturation, plus the six-sector color and blend stages; the
// CORDIC for the hue runs alongside. A stall on the output freezes the whole pipeline and
// is passed straight back as a stall on the input, so no pixel is dropped or repeated.
// The radius and ground color registers are written through a simple write port and must
// only be changed while no pixel is in flight.
module hue_wheel_pixel_generator_top import hwpg_pkg::*; #(
    parameter int MAX_RADIUS = HWPG_MAX_RADIUS,
    parameter int HUE_BITS   = HWPG_HUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pix_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_pix_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Stages after the divider: sector setup, products, mix numerators, channel colors.
    localparam int VLD_LEN = 1 + DIST_LAT + 4;
    localparam int PW      = HUE_BITS + 17;
    localparam int MW      = HUE_BITS + 25;
    localparam logic [HUE_BITS:0] HUE_ONE = (HUE_BITS + 1)'(1) << HUE_BITS;
    localparam logic [PW-1:0]     MIX_ONE = PW'(1) << (16 + HUE_BITS);

    // Configuration registers.
    logic [RAD_W-1:0] r_disc_radius;
    logic [7:0]       r_gnd_r;
    logic [7:0]       r_gnd_g;
    logic [7:0]       r_gnd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc_radius <= RADIUS_RESET;
            r_gnd_r       <= '0;
            r_gnd_g       <= '0;
            r_gnd_b       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS: r_disc_radius <= i_cfg_data;
                CFG_GND_R:  r_gnd_r       <= i_cfg_data[7:0];
                CFG_GND_G:  r_gnd_g       <= i_cfg_data[7:0];
                CFG_GND_B:  r_gnd_b       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The radius in use is clamped to the supported range; the user must keep it static while
    // pixels flow (the block itself does not enforce this), so every stage reads it directly.
    logic [RAD_W-1:0] w_radius;

    always_comb begin
        if (r_disc_radius < RAD_W'(RAD_MIN)) begin
            w_radius = RAD_W'(RAD_MIN);
        end else if (32'(r_disc_radius) > MAX_RADIUS) begin
            w_radius = RAD_W'(MAX_RADIUS);
        end else begin
            w_radius = r_disc_radius;
        end
    end

    // The pipeline moves as one whenever the output register is free or being emptied.
    logic w_adv;

    assign o_in_stall = o_out_valid & i_out_stall;
    assign w_adv      = ~o_in_stall;

    logic r_vld [VLD_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VLD_LEN; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < VLD_LEN; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Offsets from the disc center to the pixel center in half pixels, y pointing up.
    logic signed [EX_W-1:0] r_ex;
    logic signed [EX_W-1:0] r_ey;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ex <= $signed({1'b0, i_in_data.pixel_x, 1'b1}) - $signed({1'b0, w_radius, 1'b0});
            r_ey <= $signed({1'b0, w_radius, 1'b0}) - $signed({1'b0, i_in_data.pixel_y, 1'b1});
        end
    end

    logic [D_W-1:0]      w_dist;
    logic [SAT_W-1:0]    w_sat;
    logic [HUE_BITS-1:0] w_hue;

    hwpg_dist u_dist (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_ex     (r_ex),
        .i_ey     (r_ey),
        .i_radius (w_radius),
        .o_dist   (w_dist),
        .o_sat    (w_sat)
    );

    hwpg_cordic #(
        .HUE_BITS (HUE_BITS)
    ) u_cordic (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_ex  (r_ex),
        .i_ey  (r_ey),
        .o_hue (w_hue)
    );

    // The hue is ready before the saturation; hold it back to line up.
    logic [HUE_BITS-1:0] r_hue_dly [HUE_DLY];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue_dly[0] <= w_hue;
            for (int k = 1; k < HUE_DLY; k++) begin
                r_hue_dly[k] <= r_hue_dly[k-1];
            end
        end
    end

    // Sector and fraction of the hue, and the rim coverage.
    logic [HUE_BITS+2:0] w_t;
    logic [D_W-1:0]      w_lim;
    logic [D_W-1:0]      w_diff;
    logic [8:0]          n_cov;
    t_sector             r_h1_sec;
    logic [HUE_BITS-1:0] r_h1_f;
    logic [SAT_W-1:0]    r_h1_sat;
    logic [8:0]          r_h1_cov;

    assign w_t    = ((HUE_BITS + 3)'(r_hue_dly[HUE_DLY-1]) << 2)
                  + ((HUE_BITS + 3)'(r_hue_dly[HUE_DLY-1]) << 1);
    assign w_lim  = D_W'({w_radius, 8'd0});
    assign w_diff = w_lim - w_dist;

    always_comb begin
        if (w_dist >= w_lim) begin
            n_cov = 9'd0;
        end else if (w_diff >= D_W'(256)) begin
            n_cov = 9'd256;
        end else begin
            n_cov = w_diff[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h1_sec <= t_sector'(w_t[HUE_BITS+2 -: 3]);
            r_h1_f   <= w_t[HUE_BITS-1:0];
            r_h1_sat <= w_sat;
            r_h1_cov <= n_cov;
        end
    end

    // Saturation times one minus the level for each of the three mix points.
    logic [HUE_BITS:0] w_one_f;
    logic [PW-1:0]     r_p_lo;
    logic [PW-1:0]     r_p_up;
    logic [PW-1:0]     r_p_dn;
    t_sector           r_h2_sec;
    logic [8:0]        r_h2_cov;

    assign w_one_f = HUE_ONE - (HUE_BITS + 1)'(r_h1_f);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_lo   <= PW'(r_h1_sat) << HUE_BITS;
            r_p_up   <= PW'(r_h1_sat) * PW'(w_one_f);
            r_p_dn   <= PW'(r_h1_sat) * PW'(r_h1_f);
            r_h2_sec <= r_h1_sec;
            r_h2_cov <= r_h1_cov;
        end
    end

    logic [PW-1:0] r_n_lo;
    logic [PW-1:0] r_n_up;
    logic [PW-1:0] r_n_dn;
    t_sector       r_h3_sec;
    logic [8:0]    r_h3_cov;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n_lo   <= MIX_ONE - r_p_lo;
            r_n_up   <= MIX_ONE - r_p_up;
            r_n_dn   <= MIX_ONE - r_p_dn;
            r_h3_sec <= r_h2_sec;
            r_h3_cov <= r_h2_cov;
        end
    end

    // Scale a mix numerator to 0..255 with rounding.
    function automatic logic [7:0] mix_of(input logic [PW-1:0] n);
        logic [MW-1:0] m;
        m = (MW'(n) << 8) - MW'(n) + (MW'(1) << (15 + HUE_BITS));
        return m[16 + HUE_BITS +: 8];
    endfunction

    logic [7:0] w_lo;
    logic [7:0] w_upv;
    logic [7:0] w_dnv;
    logic [7:0] n_cr;
    logic [7:0] n_cg;
    logic [7:0] n_cb;
    logic [7:0] r_cr;
    logic [7:0] r_cg;
    logic [7:0] r_cb;
    logic [8:0] r_h4_cov;

    assign w_lo  = mix_of(r_n_lo);
    assign w_upv = mix_of(r_n_up);
    assign w_dnv = mix_of(r_n_dn);

    always_comb begin
        unique case (r_h3_sec)
            SEC_RED_YEL: begin
                n_cr = 8'd255; n_cg = w_upv;  n_cb = w_lo;
            end
            SEC_YEL_GRN: begin
                n_cr = w_dnv;  n_cg = 8'd255; n_cb = w_lo;
            end
            SEC_GRN_CYN: begin
                n_cr = w_lo;   n_cg = 8'd255; n_cb = w_upv;
            end
            SEC_CYN_BLU: begin
                n_cr = w_lo;   n_cg = w_dnv;  n_cb = 8'd255;
            end
            SEC_BLU_MAG: begin
                n_cr = w_upv;  n_cg = w_lo;   n_cb = 8'd255;
            end
            default: begin
                n_cr = 8'd255; n_cg = w_lo;   n_cb = w_dnv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cr     <= n_cr;
            r_cg     <= n_cg;
            r_cb     <= n_cb;
            r_h4_cov <= r_h3_cov;
        end
    end

    // Blend over the ground color. Outside the disc the coverage is zero, so the ground
    // color comes through unchanged whatever the disc color holds.
    function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] g,
                                         input logic [8:0] cov);
        logic [16:0] s;
        s = 17'(c) * 17'(cov) + 17'(g) * 17'(9'd256 - cov) + 17'd128;
        return s[15:8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_vld[VLD_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_data.red   <= blend(r_cr, r_gnd_r, r_h4_cov);
            o_out_data.green <= blend(r_cg, r_gnd_g, r_h4_cov);
            o_out_data.blue  <= blend(r_cb, r_gnd_b, r_h4_cov);
        end
    end

endmodule

[rtl/core/hwpg_checker.sv]
// Port-level checks for the hue wheel pixel generator.
module hwpg_checker import hwpg_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_pix_out o_out_data
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output data changed while stalled");

    // The input is held off exactly when a result waits on a stalled output.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow the output side");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind hue_wheel_pixel_generator_top hwpg_checker u_hwpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
